### hw/rtl/mfbp_pkg.sv
// Shared constants of the MSB-first bit packer: field widths, action codes
// and the reset value of the output limit register.
// No dependencies; every other file of the block but mfbp_queue imports it.
package mfbp_pkg;

    localparam int BYTE_W      = 8;
    localparam int BIT_COUNT_W = 6;
    localparam int VALUE_W     = 32;
    localparam int LIMIT_W     = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hffff;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

endpackage

### hw/rtl/mfbp_if.sv
// Valid/ready channel interfaces of the MSB-first bit packer: one for
// input requests and one for emitted byte results. Depends on mfbp_pkg.
interface mfbp_item_if
    import mfbp_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [BIT_COUNT_W-1:0] bit_count;
    logic [VALUE_W-1:0]     value;

    modport source (output valid, output action, output bit_count, output value,
                    input ready);
    modport sink   (input valid, input action, input bit_count, input value,
                    output ready);
endinterface

interface mfbp_result_if
    import mfbp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              overflow;
    logic              last;

    modport source (output valid, output out_byte, output byte_valid,
                    output overflow, output last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input overflow, input last, output ready);
endinterface

### hw/rtl/mfbp_front.sv
// Front end of the bit packer: accepts requests, merges the field into the
// partial byte and queues the completed bytes as one job. Depends on mfbp_pkg.
module mfbp_front
    import mfbp_pkg::*;
#(
    parameter int MAX_FIELD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    mfbp_item_if.sink            item,
    input  logic                 q_full,
    output logic                 q_wr,
    output logic [((MAX_FIELD_BITS+7)/8)*8 + $clog2((MAX_FIELD_BITS+7)/8+1) - 1:0] q_wdata
);

    localparam int CNT_W     = $clog2(MAX_FIELD_BITS + 1);
    localparam int TOT_W     = CNT_W + 1;
    localparam int ACC_W     = MAX_FIELD_BITS + 7;
    localparam int JOB_BYTES = (MAX_FIELD_BITS + 7) / 8;
    localparam int JOB_W     = JOB_BYTES * 8;
    localparam int NB_W      = $clog2(JOB_BYTES + 1);

    logic [BYTE_W-1:0] partial_reg, partial_next;
    logic [2:0]        used_reg, used_next;

    logic              accept;
    logic [CNT_W-1:0]  cnt;
    logic [ACC_W-1:0]  val_ext;
    logic [ACC_W-1:0]  val_mask;
    logic [ACC_W-1:0]  combined;
    logic [ACC_W-1:0]  shifted;
    logic [TOT_W-1:0]  total;
    logic [2:0]        rem;
    logic [NB_W-1:0]   nbytes;

    assign item.ready = !q_full;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        if (item.action == ACT_FLUSH)
        begin
            // A flush pads the free places with zeros; an empty byte stays put.
            if (used_reg == 3'd0)
                cnt = '0;
            else
                cnt = CNT_W'(4'd8 - {1'b0, used_reg});
            val_ext = '0;
        end
        else
        begin
            if (32'(item.bit_count) > 32'(MAX_FIELD_BITS))
                cnt = CNT_W'(MAX_FIELD_BITS);
            else
                cnt = CNT_W'(item.bit_count);
            val_ext = ACC_W'(item.value);
        end

        val_mask = ~({ACC_W{1'b1}} << cnt);
        combined = (ACC_W'(partial_reg) << cnt) | (val_ext & val_mask);
        total    = TOT_W'(used_reg) + TOT_W'(cnt);
        rem      = total[2:0];
        nbytes   = NB_W'(total >> 3);
        // Completed bytes sit above the leftover bits.
        shifted  = combined >> rem;

        partial_next = combined[BYTE_W-1:0] & ~(8'hff << rem);
        used_next    = rem;
    end

    assign q_wr    = accept && (nbytes != '0);
    assign q_wdata = {JOB_W'(shifted), nbytes};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            used_reg    <= '0;
        end
        else if (accept)
        begin
            partial_reg <= partial_next;
            used_reg    <= used_next;
        end
    end

endmodule

### hw/rtl/mfbp_queue.sv
// Short register queue that decouples the packer front end from the byte
// emitter. No dependencies.
module mfbp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             rd,
    output logic             full,
    output logic             not_empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][WIDTH-1:0] entry_reg;
    logic [PTR_W-1:0]            wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]            rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        do_wr, do_rd;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = entry_reg[rd_ptr_reg];
    assign do_wr     = wr && !full;
    assign do_rd     = rd && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            if (wr_ptr_reg == PTR_W'(DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            if (rd_ptr_reg == PTR_W'(DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wdata;
    end

endmodule

### hw/rtl/mfbp_back.sv
// Back end of the bit packer: takes queued jobs and emits their bytes one per
// cycle unless the receiver stalls, applying the output limit. Uses mfbp_pkg.
module mfbp_back
    import mfbp_pkg::*;
#(
    parameter int MAX_FIELD_BITS = 32,
    parameter int POSITION_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [LIMIT_W-1:0] out_limit,
    input  logic               q_valid,
    input  logic [((MAX_FIELD_BITS+7)/8)*8 + $clog2((MAX_FIELD_BITS+7)/8+1) - 1:0] q_rdata,
    output logic               q_pop,
    mfbp_result_if.source      result
);

    localparam int JOB_BYTES = (MAX_FIELD_BITS + 7) / 8;
    localparam int JOB_W     = JOB_BYTES * 8;
    localparam int NB_W      = $clog2(JOB_BYTES + 1);
    localparam int IDX_W     = (JOB_BYTES > 1) ? $clog2(JOB_BYTES) : 1;
    localparam int CMP_W     = (POSITION_BITS > LIMIT_W) ? POSITION_BITS : LIMIT_W;

    logic [JOB_BYTES-1:0][BYTE_W-1:0] data_reg;
    logic [NB_W-1:0]                  rem_reg, rem_next;
    logic [POSITION_BITS-1:0]         pos_reg, pos_next;
    logic                             out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]                byte_reg;
    logic                             bvalid_reg;
    logic                             overflow_reg;
    logic                             last_reg;

    logic                             load_out;
    logic                             full;
    logic [IDX_W-1:0]                 idx;
    logic [JOB_W-1:0]                 q_data;
    logic [NB_W-1:0]                  q_nbytes;

    assign q_data   = q_rdata[JOB_W+NB_W-1:NB_W];
    assign q_nbytes = q_rdata[NB_W-1:0];

    // The output register takes a new byte when it is empty or being drained.
    assign load_out = (rem_reg != '0) && (!out_valid_reg || result.ready);
    // A saturated position counter counts as a full buffer.
    assign full     = (CMP_W'(pos_reg) >= CMP_W'(out_limit)) ||
                      (pos_reg == {POSITION_BITS{1'b1}});
    assign idx      = IDX_W'(rem_reg - 1'b1);
    assign q_pop    = q_valid && ((rem_reg == '0) || (load_out && rem_reg == NB_W'(1)));

    always_comb
    begin
        rem_next = rem_reg;
        if (q_pop)
            rem_next = q_nbytes;
        else if (load_out)
            rem_next = rem_reg - 1'b1;

        pos_next = pos_reg;
        if (load_out && !full)
            pos_next = pos_reg + 1'b1;

        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            data_reg <= q_data;
        if (load_out)
        begin
            byte_reg     <= full ? '0 : data_reg[idx];
            bvalid_reg   <= !full;
            overflow_reg <= full;
            last_reg     <= (rem_reg == NB_W'(1));
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.out_byte   = byte_reg;
    assign result.byte_valid = bvalid_reg;
    assign result.overflow   = overflow_reg;
    assign result.last       = last_reg;

endmodule

### hw/rtl/msb_first_bit_packer.sv
// MSB-first bit packer, top level.
// Depends on mfbp_pkg, the channel interfaces, mfbp_front, mfbp_queue, mfbp_back.
//
// Requests arrive on the item channel (valid/ready): a write appends the low
// bit_count bits of value (clamped to MAX_FIELD_BITS) most significant bit
// first; a flush pads a pending partial byte with zeros. Each completed byte
// leaves on the result channel as one item, the final one of a request marked
// with last. A request that completes no byte produces no result.
// The front end merges a request into the partial byte in the cycle it is
// accepted and queues its bytes; it takes a request every cycle while the
// two-entry job queue has room. The back end emits one byte per cycle while
// the receiver is ready; a request completes up to 4 bytes at the default
// field width. Its bytes pass through the job queue and the result
// register. Once the emitted byte count reaches out_limit, bytes are
// dropped and reported with overflow set and byte_valid clear.
// When the receiver stalls, the result register holds its byte, the queue
// fills and then item.ready drops. Reset empties the queue, clears the
// partial byte and byte count, and sets out_limit to 65535; cfg_we writes it.
module msb_first_bit_packer
    import mfbp_pkg::*;
#(
    parameter int MAX_FIELD_BITS = 32,
    parameter int POSITION_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    mfbp_item_if.sink          item,
    mfbp_result_if.source      result
);

    localparam int JOB_BYTES = (MAX_FIELD_BITS + 7) / 8;
    localparam int Q_W       = JOB_BYTES * 8 + $clog2(JOB_BYTES + 1);

    logic [LIMIT_W-1:0] limit_reg;
    logic               q_wr, q_full, q_valid, q_pop;
    logic [Q_W-1:0]     q_wdata, q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    mfbp_front #(
        .MAX_FIELD_BITS(MAX_FIELD_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .q_full (q_full),
        .q_wr   (q_wr),
        .q_wdata(q_wdata)
    );

    mfbp_queue #(
        .WIDTH(Q_W),
        .DEPTH(2)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wdata    (q_wdata),
        .rd       (q_pop),
        .full     (q_full),
        .not_empty(q_valid),
        .rdata    (q_rdata)
    );

    mfbp_back #(
        .MAX_FIELD_BITS(MAX_FIELD_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .out_limit(limit_reg),
        .q_valid  (q_valid),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .result   (result)
    );

endmodule
